// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the command decoder.
// Uses no other file; simulation gets the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== src/acd_pkg.sv =====
// Types, keyword table and fixed-point constants of the ASCII command decoder.
// Depends on nothing; imported by the decoder top level.
`timescale 1ns / 1ps
package acd_pkg;

   localparam int KW_COUNT    = 26;
   localparam int KW_MAX      = 10;
   localparam int FRAC_BITS   = 16;
   localparam int INT_W       = 31 - FRAC_BITS;
   localparam int MAX_FD      = 6;
   localparam int FRAC_ACC_W  = 20;
   localparam int FRAC_CNT_W  = 3;
   localparam int POW_W       = 24;
   localparam int RECIP_W     = 17;
   localparam int PROD_W      = FRAC_ACC_W + RECIP_W;
   localparam int QEST_W      = FRAC_BITS;
   localparam int FRAC_W      = FRAC_BITS + 1;
   localparam int NUM_W       = QEST_W + POW_W;

   localparam logic [INT_W-1:0] INT_LIMIT = {INT_W{1'b1}};

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_POINT = 8'h2E;

   typedef enum logic [3:0] {
      PH_SPACE  = 4'b0001,
      PH_WORD   = 4'b0010,
      PH_VALUE  = 4'b0100,
      PH_IGNORE = 4'b1000
   } line_phase_type;

   typedef enum logic [3:0] {
      NP_SIGN = 4'b0001,
      NP_INT  = 4'b0010,
      NP_FRAC = 4'b0100,
      NP_STOP = 4'b1000
   } number_phase_type;

   typedef enum logic [1:0] {
      ST_MATCH   = 2'd0,
      ST_UNKNOWN = 2'd1,
      ST_NO_WORD = 2'd2
   } status_type;

   // Keywords are stored right aligned: the first character is the highest byte in use.
   localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
      "start", "stop", "cp", "ci", "sp", "si", "kp", "ki", "sc", "speed",
      "currmodel", "speedmodel", "speedmode", "posimodel", "posmode",
      "vfmodel", "vfmode", "clearfault", "ratune", "satune", "nodeget",
      "nodeset", "calib", "calibstop", "flashread", "flashclear"
   };

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd5, 4'd4, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd5,
      4'd9, 4'd10, 4'd9, 4'd9, 4'd7, 4'd7, 4'd6, 4'd10, 4'd6, 4'd6,
      4'd7, 4'd7, 4'd5, 4'd9, 4'd9, 4'd10
   };

   // Powers of ten and reciprocals floor(2^(FRAC_BITS+s)/10^n), with 10^n <= 2^s; RECIP[0] is 0.
   localparam logic [POW_W-1:0] POW10 [8] = '{
      24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000,
      24'd1000000, 24'd10000000
   };
   localparam logic [RECIP_W-1:0] RECIP [8] = '{
      17'd0, 17'd104857, 17'd83886, 17'd67108, 17'd107374, 17'd85899,
      17'd68719, 17'd109951
   };
   localparam logic [4:0] RECIP_SHIFT [8] = '{
      5'd0, 5'd4, 5'd7, 5'd10, 5'd14, 5'd17, 5'd20, 5'd24
   };

   typedef struct packed {
      logic                   word_seen;
      logic [KW_COUNT-1:0]    mask;
      logic [3:0]             wlen;
      logic                   ovf;
      logic                   given;
      logic                   neg;
      logic [INT_W-1:0]       int_part;
      logic [FRAC_ACC_W-1:0]  frac_acc;
      logic [FRAC_CNT_W-1:0]  frac_cnt;
   } s1_type;

   typedef struct packed {
      status_type             status;
      logic [4:0]             index;
      logic                   given;
      logic                   use_value;
      logic                   neg;
      logic [INT_W-1:0]       int_part;
      logic [FRAC_ACC_W-1:0]  frac_acc;
      logic [FRAC_CNT_W-1:0]  frac_cnt;
      logic [QEST_W-1:0]      q_est;
   } s2_type;

   typedef struct packed {
      status_type             status;
      logic [4:0]             index;
      logic                   given;
      logic                   use_value;
      logic                   neg;
      logic [INT_W-1:0]       int_part;
      logic [FRAC_CNT_W-1:0]  frac_cnt;
      logic [QEST_W-1:0]      q_est;
      logic [NUM_W-1:0]       numer;
      logic [NUM_W-1:0]       qp;
   } s3_type;

   typedef struct packed {
      status_type             status;
      logic [4:0]             index;
      logic                   given;
      logic                   use_value;
      logic                   neg;
      logic [INT_W-1:0]       int_part;
      logic [FRAC_W-1:0]      frac;
   } s4_type;

   function automatic logic [7:0] kw_char(input logic [4:0] e, input logic [3:0] pos);
      logic [7:0] c;
      logic [3:0] len;
      int         sh;
      len = KW_LEN[e];
      c   = 8'h00;
      sh  = (int'(len) - int'(pos) - 1) * 8;
      if (pos < len) begin
         c = KW_TEXT[e][sh +: 8];
      end
      return c;
   endfunction

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

endpackage

// ===== src/ascii_command_decoder_top.sv =====
// ASCII command decoder: keyword match and fixed-point argument parse per line.
// Depends on acd_pkg and assert_macros.svh.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_stall | req_data_byte, req_last_byte
//   rsp     | out       | rsp_valid / rsp_stall | rsp_status, rsp_command_index,
//           |           |                       | rsp_value, rsp_value_given
//
// One byte is taken every cycle while req_stall is low. A result is produced only for the
// last byte of a line and passes through stages 1 to 4 into the output register; the depth is
// set by the reciprocal multiply, the remainder multiply and the correction stages.
// Reset is synchronous and clears the line state and all stage valid bits.
// The four stages and the output register close up bubbles, so req_stall rises only
// when all of them hold a result and rsp_stall is high.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ascii_command_decoder_top
   import acd_pkg::*;
#(
   parameter int VALUE_BUFFER_SIZE = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_command_index,
   output logic signed [31:0] rsp_value,
   output logic        rsp_value_given
);

   localparam int VCT_W = $clog2(VALUE_BUFFER_SIZE);
   localparam logic [VCT_W-1:0] TAKE_MAX = VCT_W'(VALUE_BUFFER_SIZE - 1);

   // Line state.
   line_phase_type         line_phase_ff, line_phase_in, line_phase_upd;
   number_phase_type       num_phase_ff, num_phase_in, num_phase_upd;
   logic [KW_COUNT-1:0]    mask_ff, mask_in, mask_upd;
   logic [3:0]             wlen_ff, wlen_in, wlen_upd;
   logic                   ovf_ff, ovf_in, ovf_upd;
   logic [VCT_W-1:0]       vct_ff, vct_in, vct_upd;
   logic                   neg_ff, neg_in, neg_upd;
   logic [INT_W-1:0]       int_ff, int_in, int_upd;
   logic [FRAC_ACC_W-1:0]  frac_ff, frac_in, frac_upd;
   logic [FRAC_CNT_W-1:0]  fcnt_ff, fcnt_in, fcnt_upd;

   // Result pipeline.
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   logic   v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic   rdy1, rdy2, rdy3, rdy4, rdy5;
   status_type         rsp_status_ff, rsp_status_in;
   logic [4:0]         rsp_index_ff, rsp_index_in;
   logic [31:0]        rsp_value_ff, rsp_value_in;
   logic               rsp_given_ff, rsp_given_in;

   logic                  req_accept;
   logic [KW_COUNT-1:0]   letter_hit;
   logic [3:0]            digit;
   logic [INT_W+3:0]      int_grown;
   logic [FRAC_ACC_W+3:0] frac_grown;
   logic                  found;
   logic [4:0]            found_idx;
   logic [PROD_W-1:0]     recip_prod;
   logic [NUM_W-1:0]      remainder;
   logic [NUM_W-1:0]      pow_ext;
   logic [31:0]           mag;
   logic [31:0]           mag_sat;

   assign rdy5 = !v5_ff || !rsp_stall;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_stall  = !rdy1;
   assign req_accept = req_valid && rdy1;

   assign digit      = req_data_byte[3:0];
   assign int_grown  = {4'b0, int_ff} * (INT_W+4)'(10) + (INT_W+4)'(digit);
   assign frac_grown = {4'b0, frac_ff} * (FRAC_ACC_W+4)'(10) + (FRAC_ACC_W+4)'(digit);

   always_comb begin
      for (int e = 0; e < KW_COUNT; e++) begin
         letter_hit[e] = (kw_char(5'(e), wlen_ff) == req_data_byte);
      end
   end

   // Effect of the current byte on the line state.
   always_comb begin
      line_phase_upd = line_phase_ff;
      num_phase_upd  = num_phase_ff;
      mask_upd       = mask_ff;
      wlen_upd       = wlen_ff;
      ovf_upd        = ovf_ff;
      vct_upd        = vct_ff;
      neg_upd        = neg_ff;
      int_upd        = int_ff;
      frac_upd       = frac_ff;
      fcnt_upd       = fcnt_ff;
      unique case (line_phase_ff)
         PH_SPACE, PH_WORD: begin
            if (is_letter(req_data_byte)) begin
               line_phase_upd = PH_WORD;
               mask_upd       = mask_ff & letter_hit;
               if (wlen_ff != 4'd15) begin
                  wlen_upd = wlen_ff + 4'd1;
               end else begin
                  ovf_upd = 1'b1;
               end
            end else if (line_phase_ff == PH_WORD) begin
               line_phase_upd = PH_VALUE;
            end else if (req_data_byte != CH_SPACE) begin
               line_phase_upd = PH_IGNORE;
            end
         end
         PH_VALUE: begin
            if (vct_ff < TAKE_MAX) begin
               vct_upd = vct_ff + VCT_W'(1);
               unique case (num_phase_ff)
                  NP_SIGN, NP_INT: begin
                     if (is_digit(req_data_byte)) begin
                        int_upd       = (int_grown > (INT_W+4)'(INT_LIMIT)) ?
                                        INT_LIMIT : int_grown[INT_W-1:0];
                        num_phase_upd = NP_INT;
                     end else if (req_data_byte == CH_POINT) begin
                        num_phase_upd = NP_FRAC;
                     end else if (num_phase_ff == NP_SIGN &&
                                  req_data_byte == CH_MINUS) begin
                        neg_upd       = 1'b1;
                        num_phase_upd = NP_INT;
                     end else if (num_phase_ff == NP_SIGN &&
                                  req_data_byte == CH_PLUS) begin
                        num_phase_upd = NP_INT;
                     end else begin
                        num_phase_upd = NP_STOP;
                     end
                  end
                  NP_FRAC: begin
                     if (is_digit(req_data_byte)) begin
                        if (fcnt_ff < FRAC_CNT_W'(MAX_FD)) begin
                           frac_upd = frac_grown[FRAC_ACC_W-1:0];
                           fcnt_upd = fcnt_ff + FRAC_CNT_W'(1);
                        end
                     end else begin
                        num_phase_upd = NP_STOP;
                     end
                  end
                  NP_STOP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         PH_IGNORE: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      line_phase_in = line_phase_ff;
      num_phase_in  = num_phase_ff;
      mask_in       = mask_ff;
      wlen_in       = wlen_ff;
      ovf_in        = ovf_ff;
      vct_in        = vct_ff;
      neg_in        = neg_ff;
      int_in        = int_ff;
      frac_in       = frac_ff;
      fcnt_in       = fcnt_ff;
      if (req_accept) begin
         if (req_last_byte) begin
            line_phase_in = PH_SPACE;
            num_phase_in  = NP_SIGN;
            mask_in       = {KW_COUNT{1'b1}};
            wlen_in       = '0;
            ovf_in        = 1'b0;
            vct_in        = '0;
            neg_in        = 1'b0;
            int_in        = '0;
            frac_in       = '0;
            fcnt_in       = '0;
         end else begin
            line_phase_in = line_phase_upd;
            num_phase_in  = num_phase_upd;
            mask_in       = mask_upd;
            wlen_in       = wlen_upd;
            ovf_in        = ovf_upd;
            vct_in        = vct_upd;
            neg_in        = neg_upd;
            int_in        = int_upd;
            frac_in       = frac_upd;
            fcnt_in       = fcnt_upd;
         end
      end
   end

   // Stage 1 holds the finished line summary.
   always_comb begin
      s1_in.word_seen = (line_phase_upd == PH_WORD) || (line_phase_upd == PH_VALUE);
      s1_in.mask      = mask_upd;
      s1_in.wlen      = wlen_upd;
      s1_in.ovf       = ovf_upd;
      s1_in.given     = (vct_upd != '0);
      s1_in.neg       = neg_upd;
      s1_in.int_part  = int_upd;
      s1_in.frac_acc  = frac_upd;
      s1_in.frac_cnt  = fcnt_upd;
   end

   // Stage 2: keyword lookup and reciprocal estimate of the fraction.
   always_comb begin
      found     = 1'b0;
      found_idx = '0;
      for (int e = KW_COUNT - 1; e >= 0; e--) begin
         if (s1_ff.mask[e] && KW_LEN[e] == s1_ff.wlen) begin
            found     = 1'b1;
            found_idx = 5'(e);
         end
      end
      recip_prod = PROD_W'(s1_ff.frac_acc) * PROD_W'(RECIP[s1_ff.frac_cnt]);
      if (!s1_ff.word_seen) begin
         s2_in.status = ST_NO_WORD;
      end else if (found && !s1_ff.ovf) begin
         s2_in.status = ST_MATCH;
      end else begin
         s2_in.status = ST_UNKNOWN;
      end
      s2_in.index     = (s2_in.status == ST_MATCH) ? found_idx : 5'd0;
      s2_in.given     = s1_ff.given;
      s2_in.use_value = (s2_in.status == ST_MATCH) && s1_ff.given;
      s2_in.neg       = s1_ff.neg;
      s2_in.int_part  = s1_ff.int_part;
      s2_in.frac_acc  = s1_ff.frac_acc;
      s2_in.frac_cnt  = s1_ff.frac_cnt;
      s2_in.q_est     = QEST_W'(recip_prod >> RECIP_SHIFT[s1_ff.frac_cnt]);
   end

   // Stage 3: back-multiply the estimate and form the rounded numerator.
   always_comb begin
      s3_in.status    = s2_ff.status;
      s3_in.index     = s2_ff.index;
      s3_in.given     = s2_ff.given;
      s3_in.use_value = s2_ff.use_value;
      s3_in.neg       = s2_ff.neg;
      s3_in.int_part  = s2_ff.int_part;
      s3_in.frac_cnt  = s2_ff.frac_cnt;
      s3_in.q_est     = s2_ff.q_est;
      s3_in.qp        = NUM_W'(s2_ff.q_est) * NUM_W'(POW10[s2_ff.frac_cnt]);
      s3_in.numer     = (NUM_W'(s2_ff.frac_acc) << FRAC_BITS) +
                        NUM_W'(POW10[s2_ff.frac_cnt] >> 1);
   end

   // Stage 4: the estimate is low by at most two; the remainder decides.
   always_comb begin
      pow_ext         = NUM_W'(POW10[s3_ff.frac_cnt]);
      remainder       = s3_ff.numer - s3_ff.qp;
      s4_in.status    = s3_ff.status;
      s4_in.index     = s3_ff.index;
      s4_in.given     = s3_ff.given;
      s4_in.use_value = s3_ff.use_value;
      s4_in.neg       = s3_ff.neg;
      s4_in.int_part  = s3_ff.int_part;
      s4_in.frac      = FRAC_W'(s3_ff.q_est) +
                        FRAC_W'(remainder >= pow_ext) +
                        FRAC_W'(remainder >= (pow_ext << 1));
   end

   // Output stage: combine, saturate, apply the sign.
   always_comb begin
      mag           = {1'b0, s4_ff.int_part, {FRAC_BITS{1'b0}}} + 32'(s4_ff.frac);
      mag_sat       = mag[31] ? 32'h7FFF_FFFF : mag;
      rsp_status_in = s4_ff.status;
      rsp_index_in  = s4_ff.index;
      rsp_given_in  = (s4_ff.status != ST_NO_WORD) && s4_ff.given;
      if (!s4_ff.use_value) begin
         rsp_value_in = '0;
      end else if (s4_ff.neg) begin
         rsp_value_in = 32'd0 - mag_sat;
      end else begin
         rsp_value_in = mag_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_phase_ff <= PH_SPACE;
         num_phase_ff  <= NP_SIGN;
         mask_ff       <= {KW_COUNT{1'b1}};
         wlen_ff       <= '0;
         ovf_ff        <= 1'b0;
         vct_ff        <= '0;
         neg_ff        <= 1'b0;
         int_ff        <= '0;
         frac_ff       <= '0;
         fcnt_ff       <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
         v5_ff         <= 1'b0;
      end else begin
         line_phase_ff <= line_phase_in;
         num_phase_ff  <= num_phase_in;
         mask_ff       <= mask_in;
         wlen_ff       <= wlen_in;
         ovf_ff        <= ovf_in;
         vct_ff        <= vct_in;
         neg_ff        <= neg_in;
         int_ff        <= int_in;
         frac_ff       <= frac_in;
         fcnt_ff       <= fcnt_in;
         if (rdy1) v1_ff <= req_accept && req_last_byte;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) s1_ff <= s1_in;
      if (rdy2) s2_ff <= s2_in;
      if (rdy3) s3_ff <= s3_in;
      if (rdy4) s4_ff <= s4_in;
      if (rdy5) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_given_ff  <= rsp_given_in;
      end
   end

   assign rsp_valid         = v5_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_command_index = rsp_index_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_value_given   = rsp_given_ff;

   `ASSERT_IMPLIES(a_nomatch_zero, clock, reset, v5_ff && rsp_status_ff != ST_MATCH,
      rsp_value_ff == 32'd0 && rsp_index_ff == 5'd0)
   `ASSERT_IMPLIES(a_noword_nogiven, clock, reset, v5_ff && rsp_status_ff == ST_NO_WORD,
      !rsp_given_ff)
   `ASSERT_IMPLIES(a_stall_full, clock, reset, req_stall,
      v1_ff && v2_ff && v3_ff && v4_ff && v5_ff)
   `ASSERT_NEXT(a_line_restart, clock, reset, req_accept && req_last_byte,
      line_phase_ff == PH_SPACE && vct_ff == '0)
   `ASSERT_IMPLIES(a_ovf_len, clock, reset, ovf_ff, wlen_ff == 4'd15)

endmodule

// ===== bench/ascii_command_decoder_top_tb.sv =====
// Self-checking bench for ascii_command_decoder_top: random command lines against a line decoder.
// Depends on acd_pkg and the decoder RTL; a byte driver and a result monitor run on the clock.
`timescale 1ns / 1ps
module ascii_command_decoder_top_tb
   import acd_pkg::*;
();

   localparam int VALUE_BUFFER_SIZE = 20;
   localparam int STIMULUS_BYTES    = 1600;
   localparam int IDLE_LIMIT        = 3000;
   localparam int HOLD_AT           = 700;
   localparam int HOLD_CYCLES       = 400;
   localparam logic [7:0] CH_ZERO   = "0";
   localparam logic [7:0] CH_NINE   = "9";

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } line_byte_type;

   typedef struct packed {
      status_type  status;
      logic [4:0]  index;
      logic [31:0] value;
      logic        given;
   } command_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_command_index;
   logic signed [31:0] rsp_value;
   logic        rsp_value_given;

   line_byte_type      line_bytes [$];
   command_result_type decoded_commands [$];
   string command_words [KW_COUNT] = '{
      "start", "stop", "cp", "ci", "sp", "si", "kp", "ki", "sc", "speed",
      "currmodel", "speedmodel", "speedmode", "posimodel", "posmode",
      "vfmodel", "vfmode", "clearfault", "ratune", "satune", "nodeget",
      "nodeset", "calib", "calibstop", "flashread", "flashclear"
   };

   // Line decoder state.
   line_phase_type   phase;
   number_phase_type num_phase;
   logic [7:0]       word_chars [15];
   int               word_len;
   bit               word_ovf;
   int               arg_taken;
   bit               neg;
   longint           int_acc;
   longint           frac_acc;
   int               frac_cnt;

   int  queued_bytes;
   int  accepted_bytes;
   int  error_count;
   int  idle_cycles;
   logic req_took = 1'b0;
   int  burst_left;
   int  gap_left;
   int  stall_mode;
   int  mode_left;
   int  hold_left;
   bit  hold_done;
   line_byte_type next_byte;
   command_result_type seen;

   ascii_command_decoder_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_command_index (rsp_command_index),
      .rsp_value         (rsp_value),
      .rsp_value_given   (rsp_value_given)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic bit is_num(input logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   task automatic clear_line();
      phase     = PH_SPACE;
      num_phase = NP_SIGN;
      word_len  = 0;
      word_ovf  = 0;
      arg_taken = 0;
      neg       = 0;
      int_acc   = 0;
      frac_acc  = 0;
      frac_cnt  = 0;
   endtask

   task automatic take_int_digit(input logic [7:0] b);
      int_acc = int_acc * 10 + longint'(b - CH_ZERO);
      if (int_acc > INT_LIMIT) begin
         int_acc = INT_LIMIT;
      end
   endtask

   task automatic take_argument_char(input logic [7:0] b);
      case (num_phase)
         NP_SIGN: begin
            if (b == CH_MINUS) begin
               neg = 1;
               num_phase = NP_INT;
            end else if (b == CH_PLUS) begin
               num_phase = NP_INT;
            end else if (is_num(b)) begin
               take_int_digit(b);
               num_phase = NP_INT;
            end else if (b == CH_POINT) begin
               num_phase = NP_FRAC;
            end else begin
               num_phase = NP_STOP;
            end
         end
         NP_INT: begin
            if (is_num(b)) begin
               take_int_digit(b);
            end else if (b == CH_POINT) begin
               num_phase = NP_FRAC;
            end else begin
               num_phase = NP_STOP;
            end
         end
         NP_FRAC: begin
            if (is_num(b)) begin
               // Digits past the supported precision are swallowed.
               if (frac_cnt < MAX_FD) begin
                  frac_acc = frac_acc * 10 + longint'(b - CH_ZERO);
                  frac_cnt++;
               end
            end else begin
               num_phase = NP_STOP;
            end
         end
         default: ;
      endcase
   endtask

   task automatic decode_char(input logic [7:0] b, input logic last);
      command_result_type r;
      longint p;
      longint f;
      longint mag;
      bit hit;
      if ((phase == PH_SPACE && b != CH_SPACE) || (phase == PH_WORD)) begin
         if (is_alpha(b)) begin
            if (word_len < 15) begin
               word_chars[word_len] = b;
               word_len++;
            end else begin
               word_ovf = 1;
            end
            phase = PH_WORD;
         end else begin
            phase = (phase == PH_WORD) ? PH_VALUE : PH_IGNORE;
         end
      end else if (phase == PH_VALUE && arg_taken < VALUE_BUFFER_SIZE - 1) begin
         take_argument_char(b);
         arg_taken++;
      end
      if (!last) begin
         return;
      end
      r = '{status: ST_NO_WORD, index: 5'd0, value: 32'd0, given: 1'b0};
      if (phase == PH_WORD || phase == PH_VALUE) begin
         r.status = ST_UNKNOWN;
         r.given  = (arg_taken > 0);
         for (int e = 0; e < KW_COUNT && !word_ovf && r.status != ST_MATCH; e++) begin
            hit = (command_words[e].len() == word_len);
            for (int i = 0; i < word_len && hit; i++) begin
               hit = (command_words[e][i] == word_chars[i]);
            end
            if (hit) begin
               r.status = ST_MATCH;
               r.index  = 5'(e);
            end
         end
         if (r.status == ST_MATCH && r.given) begin
            p = 1;
            repeat (frac_cnt) p = p * 10;
            f   = ((frac_acc << FRAC_BITS) + p / 2) / p;
            mag = (int_acc << FRAC_BITS) + f;
            if (mag > 64'h7FFF_FFFF) begin
               mag = 64'h7FFF_FFFF;
            end
            r.value = neg ? -mag[31:0] : mag[31:0];
         end
      end
      decoded_commands.push_back(r);
      clear_line();
   endtask

   task automatic queue_byte(input logic [7:0] b, input logic last);
      line_bytes.push_back('{data: b, last: last});
      queued_bytes++;
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         queue_byte(s[i], i == s.len() - 1);
      end
   endtask

   function automatic logic [7:0] random_letter();
      return ($urandom_range(0, 1) == 0) ? 8'("a" + $urandom_range(0, 25))
                                         : 8'("A" + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_digit();
      return 8'(CH_ZERO + $urandom_range(0, 9));
   endfunction

   task automatic queue_random_line();
      logic [7:0] chars [$];
      logic [7:0] b;
      int kind;
      int k;
      int n;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         // Noise: arbitrary bytes, most of which never get past the first states.
         repeat ($urandom_range(1, 24)) chars.push_back(8'($urandom));
      end else begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) chars.push_back(CH_SPACE);
         end
         k = $urandom_range(0, KW_COUNT - 1);
         if (kind < 75) begin
            for (int i = 0; i < command_words[k].len(); i++) chars.push_back(command_words[k][i]);
         end else if (kind < 85) begin
            // Keyword with one letter in the wrong case.
            n = $urandom_range(0, command_words[k].len() - 1);
            for (int i = 0; i < command_words[k].len(); i++) begin
               chars.push_back(command_words[k][i] ^ ((i == n) ? 8'h20 : 8'h00));
            end
         end else if (kind < 95) begin
            repeat ($urandom_range(1, 12)) chars.push_back(random_letter());
         end else begin
            repeat ($urandom_range(14, 20)) chars.push_back(random_letter());
         end
         if ($urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 9) < 7) begin
               chars.push_back(CH_SPACE);
            end else begin
               do b = 8'($urandom); while (is_alpha(b));
               chars.push_back(b);
            end
            if ($urandom_range(0, 9) != 0) begin
               if ($urandom_range(0, 19) == 0) begin
                  repeat ($urandom_range(19, 28)) chars.push_back(random_digit());
               end else begin
                  n = $urandom_range(0, 9);
                  if (n < 3) chars.push_back(CH_MINUS);
                  else if (n == 3) chars.push_back(CH_PLUS);
                  n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 3);
                  repeat (n) chars.push_back(random_digit());
                  if ($urandom_range(0, 9) < 6) begin
                     chars.push_back(CH_POINT);
                     repeat ($urandom_range(0, 9)) chars.push_back(random_digit());
                  end
                  if ($urandom_range(0, 4) == 0) begin
                     repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom));
                  end
               end
            end
         end
      end
      foreach (chars[i]) queue_byte(chars[i], i == chars.size() - 1);
   endtask

   // Byte driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (!reset && !(req_valid && !req_took)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (line_bytes.size() > 0) begin
            next_byte = line_bytes.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= next_byte.data;
            req_last_byte <= next_byte.last;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: shifting stall patterns, with one long hold-off to back the pipeline up.
   always @(negedge clock) begin
      if (!hold_done && accepted_bytes >= HOLD_AT) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 80);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 1) == 0);
            2:       rsp_stall <= ($urandom_range(0, 4) != 0);
            default: rsp_stall <= (mode_left % 3 == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      req_took <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            decode_char(req_data_byte, req_last_byte);
            accepted_bytes++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (decoded_commands.size() == 0) begin
               $display("%0t: unexpected result status %0d index %0d value %0d given %0d",
                        $time, rsp_status, rsp_command_index, rsp_value, rsp_value_given);
               error_count++;
            end else begin
               seen = decoded_commands.pop_front();
               if (rsp_status !== seen.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, seen.status, rsp_status);
                  error_count++;
               end
               if (rsp_command_index !== seen.index) begin
                  $display("%0t: command_index expected %0d actual %0d",
                           $time, seen.index, rsp_command_index);
                  error_count++;
               end
               if (rsp_value !== seen.value) begin
                  $display("%0t: value expected %h actual %h", $time, seen.value, rsp_value);
                  error_count++;
               end
               if (rsp_value_given !== seen.given) begin
                  $display("%0t: value_given expected %0d actual %0d",
                           $time, seen.given, rsp_value_given);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a request or a result.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
         $display("ascii_command_decoder_top regression: fail");
         $finish;
      end
   end

   initial begin
      clear_line();
      // Line that is a single byte with every bit set: no word.
      queue_byte(8'hFF, 1'b1);
      // Line that ends while still skipping spaces.
      queue_text(" ");
      // Leading spaces, then a keyword that ends the line.
      queue_text("  si");
      // The separator is the final byte.
      queue_text("ki ");
      // The minus sign is the separator, so the value .5 is positive with no integer digits.
      queue_text("sc-.5");
      // Saturating integer part and fraction digits past the precision.
      queue_text("cp 99999.1234567");
      while (queued_bytes < STIMULUS_BYTES) begin
         queue_random_line();
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (line_bytes.size() != 0 || req_valid) @(posedge clock);
      while (decoded_commands.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      foreach (decoded_commands[i]) begin
         $display("%0t: missing result status %0d index %0d", $time,
                  decoded_commands[i].status, decoded_commands[i].index);
         error_count++;
      end
      if (error_count == 0) begin
         $display("ascii_command_decoder_top regression: pass");
      end else begin
         $display("ascii_command_decoder_top regression: fail");
      end
      $finish;
   end

endmodule

// ===== ascii_command_decoder_top.f =====
+incdir+src
src/acd_pkg.sv
src/ascii_command_decoder_top.sv
bench/ascii_command_decoder_top_tb.sv
